// File: rtl/core/atq_pkg.sv
// Package for the alarm timer queue: item structs, codes and sizing constants.
// No dependencies.
package atq_pkg;

  localparam int unsigned DefSlots = 32;

  typedef enum logic [1:0] {
    ACT_REGISTER = 2'd0,
    ACT_CANCEL   = 2'd1,
    ACT_TICK     = 2'd2,
    ACT_ONESHOT  = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    RK_REGISTERED = 3'd0,
    RK_REJECTED   = 3'd1,
    RK_CANCELLED  = 3'd2,
    RK_NOT_FOUND  = 3'd3,
    RK_EXPIRED    = 3'd4,
    RK_DONE       = 3'd5
  } result_kind_e;

  typedef enum logic [1:0] {
    CFG_TICK_PERIOD = 2'd0,
    CFG_TICKLESS    = 2'd1,
    CFG_SLACK       = 2'd2
  } cfg_index_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_REG_DONE,
    ST_EXP_PICK,
    ST_EXP_EMIT,
    ST_EXP_UPD,
    ST_FINAL
  } state_e;

  typedef struct packed {
    logic [1:0]  action;
    logic [63:0] now_time;
    logic [63:0] deadline;
    logic [63:0] reload_period;
    logic [31:0] cancel_id;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  result_kind;
    logic [31:0] timer_id;
    logic        rearm_valid;
    logic [63:0] rearm_time;
    logic        last;
  } out_item_t;

  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? '1 : s[63:0];
  endfunction

endpackage

// File: rtl/core/alarm_timer_queue.sv
// Alarm timer queue top level: slot table, scan sequencer, rearm logic.
// Depends on atq_pkg.
// Each accepted item makes one pass over the slot table before its result; an event item
// makes one more pass for each expired item, and results wait while the output is stalled.
// Throughput: one item at a time; the next item is taken in ST_IDLE, after the last result is
// loaded. Each pass walks the slot table one slot per cycle through one 64-bit compare unit.
// Reset clears valid bits, id counter (to one), tick and armed times; config to defaults.
module alarm_timer_queue #(
  parameter int unsigned SLOTS = atq_pkg::DefSlots
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  atq_pkg::in_item_t in_item_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output atq_pkg::out_item_t out_item_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [1:0]        cfg_index_i,
  input  logic [31:0]       cfg_data_i
);
  import atq_pkg::*;

  localparam int unsigned IdxW = $clog2(SLOTS);
  localparam int unsigned CntW = $clog2(SLOTS + 1);

  logic [63:0] slot_expiry [SLOTS];
  logic [31:0] slot_id     [SLOTS];
  logic [63:0] slot_period [SLOTS];
  logic [SLOTS-1:0] valid_q;

  state_e state_q, state_d;
  in_item_t item_q;
  out_item_t out_q;
  logic out_valid_q;
  logic [31:0] tick_period_q, slack_q, id_cnt_q;
  logic tickless_q;
  logic [63:0] tick_ref_q, armed_q;
  logic [IdxW-1:0] idx_q;
  logic [IdxW-1:0] best_q, free_q, match_q;
  logic best_ok_q, free_ok_q, match_ok_q;
  logic [63:0] best_exp_q, rd_exp_q;
  logic [31:0] rd_id_q;
  logic [63:0] rd_per_q;
  logic [IdxW-1:0] rd_idx_q;
  logic rd_ok_q;
  logic [CntW-1:0] exp_cnt_q;

  logic scan_end;
  logic out_free;
  logic due;
  logic reg_ok;
  logic out_load;
  assign scan_end = (idx_q == IdxW'(SLOTS - 1));
  assign out_free = !out_valid_q || !out_stall_i;
  assign due      = best_ok_q && (best_exp_q <= item_q.now_time) &&
                    (exp_cnt_q < CntW'(SLOTS));
  assign reg_ok   = (item_q.deadline != 64'd0) && free_ok_q;
  assign out_load = out_free && (state_q == ST_EXP_UPD || state_q == ST_FINAL);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:     if (in_valid_i && !in_stall_o) state_d = ST_SCAN;
      ST_SCAN:     if (scan_end) state_d = ST_EXP_PICK;
      ST_EXP_PICK: begin
        if (item_q.action == ACT_REGISTER) state_d = ST_REG_DONE;
        else if (item_q.action == ACT_CANCEL) state_d = ST_FINAL;
        else state_d = ST_EXP_EMIT;
      end
      ST_REG_DONE: state_d = ST_FINAL;
      ST_EXP_EMIT: state_d = due ? ST_EXP_UPD : ST_FINAL;
      ST_EXP_UPD:  if (out_free) state_d = ST_SCAN;
      ST_FINAL:    if (out_free) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  assign in_stall_o  = (state_q != ST_IDLE) || cfg_valid_i;
  assign cfg_ready_o = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  logic [63:0] cand;
  logic [63:0] tick_lim;
  logic fire;
  logic [63:0] arm_ref;
  logic [63:0] new_exp;
  always_comb begin
    tick_lim = sat_add(tick_ref_q, {32'd0, tick_period_q});
    if (item_q.action == ACT_REGISTER) cand = sat_add(best_exp_q, {32'd0, slack_q});
    else cand = best_ok_q ? best_exp_q : 64'd0;
    arm_ref = (item_q.action == ACT_ONESHOT) ? 64'd0 : armed_q;
    fire = (tickless_q || cand <= tick_lim) && (cand > item_q.now_time) &&
           (arm_ref == 64'd0 || cand < arm_ref);
    new_exp = sat_add(item_q.now_time, rd_per_q);
  end

  logic [IdxW-1:0] nxt_best;
  logic nxt_ok;
  always_comb begin
    nxt_best = best_q;
    nxt_ok   = best_ok_q;
    if (rd_ok_q && (!best_ok_q || rd_exp_q < best_exp_q)) begin
      nxt_best = rd_idx_q;
      nxt_ok   = 1'b1;
    end
  end

  logic scan_rd_q;
  always_ff @(posedge clk_i) begin
    if (state_q == ST_SCAN) begin
      rd_exp_q <= slot_expiry[idx_q];
      rd_id_q  <= slot_id[idx_q];
    end else if (state_q == ST_EXP_EMIT) begin
      rd_per_q <= slot_period[best_q];
      rd_id_q  <= slot_id[best_q];
    end
    if (state_q == ST_REG_DONE && reg_ok) begin
      slot_expiry[free_q] <= item_q.deadline;
      slot_id[free_q]     <= id_cnt_q;
      slot_period[free_q] <= item_q.reload_period;
    end else if (state_q == ST_EXP_UPD && out_free) begin
      slot_expiry[best_q] <= new_exp;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      valid_q <= '0;
      out_valid_q <= 1'b0;
      tick_period_q <= 32'd1000000;
      tickless_q <= 1'b0;
      slack_q <= 32'd2000000;
      id_cnt_q <= 32'd1;
      tick_ref_q <= '0;
      armed_q <= '0;
      idx_q <= '0;
      scan_rd_q <= 1'b0;
      rd_ok_q <= 1'b0;
      rd_idx_q <= '0;
      best_ok_q <= 1'b0;
      free_ok_q <= 1'b0;
      match_ok_q <= 1'b0;
      best_q <= '0;
      free_q <= '0;
      match_q <= '0;
      best_exp_q <= '0;
      exp_cnt_q <= '0;
      item_q <= '0;
      out_q <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_TICK_PERIOD: tick_period_q <= cfg_data_i;
          CFG_TICKLESS:    tickless_q <= cfg_data_i[0];
          CFG_SLACK:       slack_q <= cfg_data_i;
          default:         ;
        endcase
      end
      out_valid_q <= out_load || (out_valid_q && out_stall_i);
      scan_rd_q <= (state_q == ST_SCAN);
      rd_idx_q  <= idx_q;
      rd_ok_q   <= (state_q == ST_SCAN) && valid_q[idx_q];
      if (scan_rd_q) begin
        best_q <= nxt_best;
        best_ok_q <= nxt_ok;
        if (rd_ok_q && (!best_ok_q || rd_exp_q < best_exp_q)) best_exp_q <= rd_exp_q;
        if (!valid_q[rd_idx_q] && !free_ok_q) begin
          free_q <= rd_idx_q;
          free_ok_q <= 1'b1;
        end
        if (rd_ok_q && !match_ok_q && rd_id_q == item_q.cancel_id &&
            item_q.cancel_id != 32'd0) begin
          match_q <= rd_idx_q;
          match_ok_q <= 1'b1;
        end
      end
      case (state_q)
        ST_IDLE: begin
          idx_q <= '0;
          best_ok_q <= 1'b0;
          free_ok_q <= 1'b0;
          match_ok_q <= 1'b0;
          exp_cnt_q <= '0;
          if (in_valid_i && !in_stall_o) begin
            item_q <= in_item_i;
            if (in_item_i.action == ACT_TICK) tick_ref_q <= in_item_i.now_time;
          end
        end
        ST_SCAN: idx_q <= scan_end ? '0 : idx_q + IdxW'(1);
        ST_REG_DONE: begin
          id_cnt_q <= (id_cnt_q == 32'hFFFF_FFFF) ? 32'd1 : id_cnt_q + 32'd1;
          if (reg_ok) begin
            valid_q[free_q] <= 1'b1;
            if (!best_ok_q || item_q.deadline < best_exp_q) begin
              best_exp_q <= item_q.deadline;
            end
            best_ok_q <= 1'b1;
          end
        end
        ST_EXP_UPD: begin
          if (out_free) begin
            out_q <= '{RK_EXPIRED, rd_id_q, 1'b0, 64'd0, 1'b0};
            if (rd_per_q == 64'd0 || !(new_exp > best_exp_q)) valid_q[best_q] <= 1'b0;
            exp_cnt_q <= exp_cnt_q + CntW'(1);
            best_ok_q <= 1'b0;
            free_ok_q <= 1'b0;
            match_ok_q <= 1'b0;
          end
        end
        ST_FINAL: begin
          if (out_free) begin
            case (item_q.action)
              ACT_REGISTER: begin
                if (reg_ok) begin
                  out_q <= '{RK_REGISTERED, (id_cnt_q == 32'd1) ? 32'hFFFF_FFFF
                             : id_cnt_q - 32'd1, fire, fire ? cand : 64'd0, 1'b1};
                  if (fire) armed_q <= cand;
                end else begin
                  out_q <= '{RK_REJECTED, 32'd0, 1'b0, 64'd0, 1'b1};
                end
              end
              ACT_CANCEL: begin
                if (match_ok_q) begin
                  valid_q[match_q] <= 1'b0;
                  out_q <= '{RK_CANCELLED, item_q.cancel_id, 1'b0, 64'd0, 1'b1};
                end else begin
                  out_q <= '{RK_NOT_FOUND, 32'd0, 1'b0, 64'd0, 1'b1};
                end
              end
              ACT_TICK: begin
                out_q <= '{RK_DONE, 32'd0, fire, fire ? cand : 64'd0, 1'b1};
                if (fire) armed_q <= cand;
              end
              ACT_ONESHOT: begin
                out_q <= '{RK_DONE, 32'd0, fire, fire ? cand : 64'd0, 1'b1};
                armed_q <= fire ? cand : 64'd0;
              end
              default: ;
            endcase
          end
        end
        default: ;
      endcase
    end
  end

  a_busy_no_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> in_stall_o) else $error("accept while busy");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_item_o)))
    else $error("output item changed under stall");
  a_id_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    id_cnt_q != 32'd0) else $error("id counter zero");

endmodule

// File: tb/atq_checker.sv
// Checker for the alarm timer queue: watches the input, output and config channels,
// predicts the result items of each accepted input item and compares them in order.
// Depends on atq_pkg.
`timescale 1ns / 1ps

module atq_checker #(
  parameter int unsigned SLOTS = atq_pkg::DefSlots
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  atq_pkg::in_item_t  in_item_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  atq_pkg::out_item_t out_item_i,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  output int                 errors_o,
  output int                 pending_o
);
  import atq_pkg::*;

  logic [63:0] tick_period_q;
  logic        tickless_q;
  logic [63:0] slack_q;

  logic        alarm_live[SLOTS];
  logic [63:0] alarm_expiry[SLOTS];
  logic [31:0] slot_tag[SLOTS];
  logic [63:0] alarm_period[SLOTS];
  logic [31:0] next_id;
  logic [63:0] tick_mark;
  logic [63:0] armed_at;

  out_item_t expected_q[$];

  function automatic logic [63:0] add_sat(logic [63:0] a, logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? 64'hFFFF_FFFF_FFFF_FFFF : s[63:0];
  endfunction

  function automatic int earliest_alarm();
    int best;
    best = -1;
    for (int i = 0; i < SLOTS; i++)
      if (alarm_live[i] && (best < 0 || alarm_expiry[i] < alarm_expiry[best])) best = i;
    return best;
  endfunction

  function automatic out_item_t result_of(result_kind_e kind, logic [31:0] id, logic rv,
                                          logic [63:0] rt, logic fin);
    out_item_t r;
    r.result_kind = kind;
    r.timer_id    = id;
    r.rearm_valid = rv;
    r.rearm_time  = rt;
    r.last        = fin;
    return r;
  endfunction

  task automatic try_rearm(input logic [63:0] cand, input logic [63:0] now,
                           output logic rv, output logic [63:0] rt);
    logic wait_tick;
    wait_tick = !tickless_q && (cand > add_sat(tick_mark, tick_period_q));
    rv = 1'b0;
    rt = '0;
    if (!wait_tick && cand > now && (armed_at == 0 || cand < armed_at)) begin
      armed_at = cand;
      rv = 1'b1;
      rt = cand;
    end
  endtask

  task automatic predict_alarms(input in_item_t it);
    logic [31:0] id;
    logic [63:0] old, ne, cand, rt;
    logic        rv;
    int          free_slot, m;
    bit          found;
    case (action_e'(it.action))
      ACT_REGISTER: begin
        id = next_id;
        next_id = (next_id == 32'hFFFF_FFFF) ? 32'd1 : next_id + 32'd1;
        free_slot = -1;
        for (int i = SLOTS - 1; i >= 0; i--) if (!alarm_live[i]) free_slot = i;
        if (it.deadline == 0 || free_slot < 0) begin
          expected_q.push_back(result_of(RK_REJECTED, '0, 1'b0, '0, 1'b1));
        end else begin
          alarm_live[free_slot]   = 1'b1;
          alarm_expiry[free_slot] = it.deadline;
          slot_tag[free_slot]     = id;
          alarm_period[free_slot] = it.reload_period;
          m = earliest_alarm();
          try_rearm(add_sat(alarm_expiry[m], slack_q), it.now_time, rv, rt);
          expected_q.push_back(result_of(RK_REGISTERED, id, rv, rt, 1'b1));
        end
      end
      ACT_CANCEL: begin
        found = 0;
        if (it.cancel_id != 0)
          for (int i = 0; i < SLOTS; i++)
            if (!found && alarm_live[i] && slot_tag[i] == it.cancel_id) begin
              alarm_live[i] = 1'b0;
              found = 1;
            end
        if (found) expected_q.push_back(result_of(RK_CANCELLED, it.cancel_id, 1'b0, '0, 1'b1));
        else expected_q.push_back(result_of(RK_NOT_FOUND, '0, 1'b0, '0, 1'b1));
      end
      default: begin
        if (action_e'(it.action) == ACT_TICK) tick_mark = it.now_time;
        for (int g = 0; g < SLOTS; g++) begin
          m = earliest_alarm();
          if (m < 0 || alarm_expiry[m] > it.now_time) break;
          old = alarm_expiry[m];
          expected_q.push_back(result_of(RK_EXPIRED, slot_tag[m], 1'b0, '0, 1'b0));
          if (alarm_period[m] != 0) begin
            ne = add_sat(it.now_time, alarm_period[m]);
            if (ne > old) alarm_expiry[m] = ne;
            else alarm_live[m] = 1'b0;
          end else begin
            alarm_live[m] = 1'b0;
          end
        end
        m = earliest_alarm();
        cand = (m >= 0) ? alarm_expiry[m] : 64'd0;
        if (action_e'(it.action) == ACT_ONESHOT) armed_at = '0;
        try_rearm(cand, it.now_time, rv, rt);
        expected_q.push_back(result_of(RK_DONE, '0, rv, rt, 1'b1));
      end
    endcase
  endtask

  task automatic report(input string msg);
    errors_o++;
    $display("%0t MISMATCH %s", $realtime, msg);
  endtask

  task automatic compare_result(input out_item_t got);
    out_item_t exp_r;
    if (expected_q.size() == 0) begin
      report($sformatf("unexpected item kind=%0d id=%0d", got.result_kind, got.timer_id));
      return;
    end
    exp_r = expected_q.pop_front();
    if (got.result_kind !== exp_r.result_kind)
      report($sformatf("result_kind %0d, want %0d", got.result_kind, exp_r.result_kind));
    if (got.timer_id !== exp_r.timer_id)
      report($sformatf("timer_id %0d, want %0d", got.timer_id, exp_r.timer_id));
    if (got.rearm_valid !== exp_r.rearm_valid)
      report($sformatf("rearm_valid %0b, want %0b", got.rearm_valid, exp_r.rearm_valid));
    if (got.rearm_time !== exp_r.rearm_time)
      report($sformatf("rearm_time %0h, want %0h", got.rearm_time, exp_r.rearm_time));
    if (got.last !== exp_r.last)
      report($sformatf("last %0b, want %0b", got.last, exp_r.last));
  endtask

  initial begin
    errors_o  = 0;
    pending_o = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_period_q = 64'd1000000;
      tickless_q    = 1'b0;
      slack_q       = 64'd2000000;
      for (int i = 0; i < SLOTS; i++) alarm_live[i] = 1'b0;
      next_id   = 32'd1;
      tick_mark = '0;
      armed_at  = '0;
      expected_q.delete();
    end else begin
      if (out_valid_i && !out_stall_i) compare_result(out_item_i);
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_e'(cfg_index_i))
          CFG_TICK_PERIOD: tick_period_q = {32'd0, cfg_data_i};
          CFG_TICKLESS:    tickless_q = cfg_data_i[0];
          CFG_SLACK:       slack_q = {32'd0, cfg_data_i};
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) predict_alarms(in_item_i);
    end
    pending_o = expected_q.size();
  end

endmodule

// File: tb/tb_alarm_timer_queue.sv
// Testbench top for the alarm timer queue: clock, reset, stimulus and verdict.
// Checking is done by atq_checker; depends on atq_pkg and the block.
`timescale 1ns / 1ps

module tb_alarm_timer_queue;
  import atq_pkg::*;

  localparam int unsigned NSLOTS = DefSlots;
  localparam int WatchLimit = 30000;
  localparam logic [63:0] MAXT = 64'hFFFF_FFFF_FFFF_FFFF;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  int        errors, pending;

  logic [63:0] now_ns = 64'd1000;
  logic [31:0] ids_given = '0;
  bit          hold_req = 0;
  int          idle_cycles = 0;
  int          burst_left = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  alarm_timer_queue #(.SLOTS(NSLOTS)) u_top (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_item_i(in_item),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_item_o(out_item),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  atq_checker #(.SLOTS(NSLOTS)) u_checker (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_stall_i(in_stall), .in_item_i(in_item),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .out_item_i(out_item),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .errors_o(errors), .pending_o(pending)
  );

  // receiver: stall pattern from a randomly chosen mode, long hold on request
  always @(posedge clk_i) begin
    int mode, cnt, hold_left;
    if (hold_req && hold_left == 0) hold_left = 500;
    if (hold_left > 0) begin
      hold_left--;
      if (hold_left == 0) hold_req = 0;
      out_stall <= 1'b1;
    end else begin
      if (cnt % 64 == 0) mode = $urandom_range(0, 3);
      cnt++;
      case (mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= cnt[3];
      endcase
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)
        || !rst_ni)
      idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WatchLimit) begin
      $display("timeout: no handshake for %0d cycles", WatchLimit);
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic offer(input action_e act, input logic [63:0] now, input logic [63:0] expiry,
                       input logic [63:0] period, input logic [31:0] cid);
    in_item.action        <= act;
    in_item.now_time      <= now;
    in_item.deadline      <= expiry;
    in_item.reload_period <= period;
    in_item.cancel_id     <= cid;
    in_valid <= 1'b1;
    do @(posedge clk_i); while (in_stall);
    if (act == ACT_REGISTER) ids_given++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      burst_left = $urandom_range(0, 12);
      repeat ($urandom_range(0, 6)) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_cfg(input cfg_index_e idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic random_item();
    int pick;
    logic [31:0] cid;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      offer(ACT_REGISTER, now_ns, now_ns + $urandom_range(1, 3000000),
            ($urandom_range(0, 1) ? 64'd0 : 64'($urandom_range(1, 2000000))), $urandom);
    end else if (pick < 55) begin
      cid = (ids_given > 40) ? $urandom_range(ids_given - 40, ids_given + 1)
                             : $urandom_range(0, ids_given + 1);
      offer(ACT_CANCEL, now_ns, {$urandom, $urandom}, {$urandom, $urandom}, cid);
    end else if (pick < 85) begin
      now_ns += $urandom_range(0, 1500000);
      offer(($urandom_range(0, 1) ? ACT_TICK : ACT_ONESHOT), now_ns, {$urandom, $urandom},
            {$urandom, $urandom}, $urandom);
    end else if (pick < 95) begin
      offer(action_e'($urandom_range(0, 3)), {$urandom, $urandom}, {$urandom, $urandom},
            {$urandom, $urandom}, $urandom);
    end else begin
      offer(action_e'($urandom_range(2, 3)), MAXT, '0, '0, '0);
    end
  endtask

  initial begin
    bit pass;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    offer(ACT_TICK, 64'd0, '0, '0, '0);
    offer(ACT_REGISTER, 64'd10, 64'd0, 64'd5, '0);
    offer(ACT_CANCEL, 64'd10, '0, '0, 32'd0);
    offer(ACT_CANCEL, 64'd10, '0, '0, 32'hFFFF_FFFF);
    offer(ACT_REGISTER, 64'd100, 64'd500, 64'd0, '0);
    offer(ACT_REGISTER, 64'd100, 64'd500, 64'd300, '0);
    offer(ACT_REGISTER, 64'd100, 64'd500, 64'd0, '0);
    offer(ACT_CANCEL, 64'd100, '0, '0, 32'd3);
    offer(ACT_REGISTER, 64'd100, MAXT, MAXT, '0);
    offer(ACT_TICK, 64'd600, '0, '0, '0);
    offer(ACT_ONESHOT, 64'd1000, '0, '0, '0);
    offer(ACT_REGISTER, 64'd1000, 64'd1500, 64'd0, '0);
    offer(ACT_ONESHOT, 64'd1001, '0, '0, '0);
    offer(ACT_TICK, MAXT - 64'd10, '0, '0, '0);
    offer(ACT_ONESHOT, MAXT, MAXT, MAXT, 32'hFFFF_FFFF);
    offer(ACT_TICK, MAXT, '0, '0, '0);
    offer(ACT_CANCEL, '0, '0, '0, 32'd5);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          write_cfg(CFG_TICK_PERIOD, 32'd1);
          write_cfg(CFG_TICKLESS, 32'd0);
          write_cfg(CFG_SLACK, 32'd0);
        end
        1: begin
          write_cfg(CFG_TICK_PERIOD, 32'hFFFF_FFFF);
          write_cfg(CFG_TICKLESS, 32'hFFFF_FFFF);
          write_cfg(CFG_SLACK, 32'hFFFF_FFFF);
        end
        2: begin
          write_cfg(CFG_TICK_PERIOD, 32'd1000000);
          write_cfg(CFG_TICKLESS, 32'd0);
          write_cfg(CFG_SLACK, 32'd2000000);
        end
        default: begin
          write_cfg(CFG_TICK_PERIOD, $urandom_range(1, 4000000));
          write_cfg(CFG_TICKLESS, $urandom);
          write_cfg(CFG_SLACK, $urandom_range(0, 4000000));
        end
      endcase
      if (ph == 1) begin
        // fill the table past capacity; the receiver holds off at the start
        hold_req = 1;
        for (int i = 0; i < NSLOTS + 3; i++)
          offer(ACT_REGISTER, now_ns, now_ns + $urandom_range(1, 900000),
                64'($urandom_range(0, 3) * 400000), '0);
        drain();
        now_ns += 2000000;
        offer(ACT_TICK, now_ns, '0, '0, '0);
      end
      for (int n = 0; n < 40; n++) random_item();
      drain();
    end

    pass = (errors == 0) && (pending == 0);
    if (pass) begin
      $display("*** PASSED ***");
    end else begin
      $display("errors=%0d left over=%0d", errors, pending);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/atq_pkg.sv
rtl/core/alarm_timer_queue.sv
tb/atq_checker.sv
tb/tb_alarm_timer_queue.sv
